@@ design/fhc_pkg.sv @@
// Package for the frame header and CRC-32 checker.
// Holds the payload, queue entry and configuration types, status codes and header constants.
// No dependencies; every design file imports it.
package fhc_pkg;

    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int unsigned CFG_IDX_W    = 8;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Magic bytes in wire order.
    localparam logic [7:0] MAGIC_BYTES [4] = '{8'h47, 8'h44, 8'h42, 8'h52};

    // Result status codes, first failing check wins.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_MAGIC     = 3'd3;
    localparam logic [2:0] ST_VERSION   = 3'd4;
    localparam logic [2:0] ST_TYPE      = 3'd5;
    localparam logic [2:0] ST_LENGTH    = 3'd6;
    localparam logic [2:0] ST_CHECKSUM  = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_BYTES  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_VERSION = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_TYPE_CODE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION_TYPE_CODE = 8'd3;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } fhc_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] header_version;
        logic [15:0] message_type;
        logic [31:0] payload_length;
        logic [31:0] header_checksum;
    } fhc_out_t;

    typedef struct packed {
        logic [31:0] max_frame_bytes;
        logic [15:0] protocol_version;
        logic [15:0] update_type_code;
        logic [15:0] action_type_code;
    } fhc_cfg_t;

    // One classified byte on its way from the front to the back.
    typedef struct packed {
        logic [7:0]           frame_byte;
        logic                 frame_end;
        logic                 is_header;
        logic [HDR_IDX_W-1:0] hdr_index;
        logic [31:0]          byte_count;  // saturated count including this byte
    } fhc_entry_t;

endpackage

@@ design/fhc_front.sv @@
// Front end of the checker: counts bytes of a frame and classifies each one.
// Depends on fhc_pkg.
module fhc_front
    import fhc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  fhc_in_t    s_data,
    output logic       push_valid,
    input  logic       push_ready,
    output fhc_entry_t push_entry
);

    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic [31:0] count_inc;
    logic        accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    // The count saturates at all ones.
    assign count_inc = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;

    always_comb begin
        push_entry.frame_byte = s_data.frame_byte;
        push_entry.frame_end  = s_data.frame_end;
        push_entry.is_header  = (count_reg < 32'(HEADER_BYTES));
        push_entry.hdr_index  = count_reg[HDR_IDX_W-1:0];
        push_entry.byte_count = count_inc;
    end

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            count_next = s_data.frame_end ? 32'd0 : count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 32'd0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

@@ design/fhc_fifo.sv @@
// Short queue between the front and back ends of the checker.
// Depends on fhc_pkg for the entry type.
module fhc_fifo
    import fhc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  fhc_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output fhc_entry_t pop_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    fhc_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != FULL_CNT);
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/fhc_back.sv @@
// Back end of the checker: assembles the header, runs the payload CRC-32,
// judges the finished frame and holds the result register. Depends on fhc_pkg.
module fhc_back
    import fhc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  fhc_cfg_t   cfg,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  fhc_entry_t pop_entry,
    output logic       m_valid,
    input  logic       m_ready,
    output fhc_out_t   m_data
);

    // Reflected CRC-32 update by one byte, eight bit steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // Per-frame state.
    logic        magic_reg,    magic_next;
    logic [15:0] version_reg,  version_next;
    logic [15:0] type_reg,     type_next;
    logic [31:0] length_reg,   length_next;
    logic [31:0] checksum_reg, checksum_next;
    logic [31:0] crc_reg,      crc_next;

    // Finished frame waiting for judgement.
    logic        fin_valid_reg;
    logic [31:0] fin_count_reg;
    logic        fin_magic_reg;
    logic [15:0] fin_version_reg;
    logic [15:0] fin_type_reg;
    logic [31:0] fin_length_reg;
    logic [31:0] fin_checksum_reg;
    logic [31:0] fin_crc_reg;

    logic        out_valid_reg;
    fhc_out_t    out_data_reg;

    logic        out_free;
    logic        fin_free;
    logic        take;
    logic        take_end;
    logic [2:0]  status_calc;

    assign out_free  = !out_valid_reg || m_ready;
    assign fin_free  = !fin_valid_reg || out_free;
    assign pop_ready = !pop_entry.frame_end || fin_free;
    assign take      = pop_valid && pop_ready;
    assign take_end  = take && pop_entry.frame_end;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // State update for the byte at the head of the queue.
    always_comb begin
        magic_next    = magic_reg;
        version_next  = version_reg;
        type_next     = type_reg;
        length_next   = length_reg;
        checksum_next = checksum_reg;
        crc_next      = crc_reg;
        if (pop_entry.is_header) begin
            priority if (pop_entry.hdr_index < HDR_IDX_W'(4)) begin
                if (pop_entry.frame_byte != MAGIC_BYTES[pop_entry.hdr_index[1:0]]) begin
                    magic_next = 1'b0;
                end
            end else if (pop_entry.hdr_index < HDR_IDX_W'(6)) begin
                version_next[{pop_entry.hdr_index[0], 3'b000} +: 8] = pop_entry.frame_byte;
            end else if (pop_entry.hdr_index < HDR_IDX_W'(8)) begin
                type_next[{pop_entry.hdr_index[0], 3'b000} +: 8] = pop_entry.frame_byte;
            end else if (pop_entry.hdr_index < HDR_IDX_W'(12)) begin
                length_next[{pop_entry.hdr_index[1:0], 3'b000} +: 8] = pop_entry.frame_byte;
            end else begin
                checksum_next[{pop_entry.hdr_index[1:0], 3'b000} +: 8] = pop_entry.frame_byte;
            end
        end else begin
            crc_next = crc_byte(crc_reg, pop_entry.frame_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg    <= 1'b1;
            version_reg  <= 16'd0;
            type_reg     <= 16'd0;
            length_reg   <= 32'd0;
            checksum_reg <= 32'd0;
            crc_reg      <= CRC_INIT;
        end else if (take_end) begin
            magic_reg    <= 1'b1;
            version_reg  <= 16'd0;
            type_reg     <= 16'd0;
            length_reg   <= 32'd0;
            checksum_reg <= 32'd0;
            crc_reg      <= CRC_INIT;
        end else if (take) begin
            magic_reg    <= magic_next;
            version_reg  <= version_next;
            type_reg     <= type_next;
            length_reg   <= length_next;
            checksum_reg <= checksum_next;
            crc_reg      <= crc_next;
        end
    end

    // Judgement of the finished frame, first failure in check order.
    always_comb begin
        priority if (fin_count_reg < 32'(HEADER_BYTES)) begin
            status_calc = ST_TRUNCATED;
        end else if (fin_count_reg > cfg.max_frame_bytes) begin
            status_calc = ST_TOO_LARGE;
        end else if (!fin_magic_reg) begin
            status_calc = ST_MAGIC;
        end else if (fin_version_reg != cfg.protocol_version) begin
            status_calc = ST_VERSION;
        end else if (fin_type_reg != cfg.update_type_code &&
                     fin_type_reg != cfg.action_type_code) begin
            status_calc = ST_TYPE;
        end else if (fin_length_reg != fin_count_reg - 32'(HEADER_BYTES)) begin
            status_calc = ST_LENGTH;
        end else if (fin_checksum_reg != fin_crc_reg) begin
            status_calc = ST_CHECKSUM;
        end else begin
            status_calc = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take_end) begin
                fin_valid_reg <= 1'b1;
            end else if (out_free) begin
                fin_valid_reg <= 1'b0;
            end
            if (out_free) begin
                out_valid_reg <= fin_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_end) begin
            fin_count_reg    <= pop_entry.byte_count;
            fin_magic_reg    <= magic_next;
            fin_version_reg  <= version_next;
            fin_type_reg     <= type_next;
            fin_length_reg   <= length_next;
            fin_checksum_reg <= checksum_next;
            fin_crc_reg      <= ~crc_next;
        end
        if (out_free && fin_valid_reg) begin
            out_data_reg.status          <= status_calc;
            out_data_reg.header_version  <= fin_version_reg;
            out_data_reg.message_type    <= fin_type_reg;
            out_data_reg.payload_length  <= fin_length_reg;
            out_data_reg.header_checksum <= fin_checksum_reg;
        end
    end

endmodule

@@ design/frame_header_crc32_checker_core.sv @@
// Top level of the frame header and CRC-32 checker.
// Depends on fhc_pkg, fhc_front, fhc_fifo and fhc_back.
//
// Channel   Direction  Payload          One transaction carries
// s_        in         fhc_in_t         one frame byte and its end-of-frame flag
// m_        out        fhc_out_t        status and header fields of one frame
// cfg_      in         index, data      one configuration register write
//
// The block takes one byte per cycle while the queue has room. A byte passes the front
// counter, then the queue, then the back end, which updates the header fields or the CRC
// with an eight-bit unrolled step; the last byte of a frame is queued, then its frame's
// fields pass the judgement registers and the result register. Reset is synchronous and
// active low; it loads the configuration defaults and clears the frame state, and no
// clearing pass follows. When m_ready is low the result register and a full judgement stage
// hold, the back end stalls on a last byte, and s_ready drops only once the queue is full.
module frame_header_crc32_checker_core
    import fhc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  fhc_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output fhc_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    fhc_cfg_t   cfg_reg;
    fhc_cfg_t   cfg_next;
    logic       cfg_write;

    logic       push_valid;
    logic       push_ready;
    fhc_entry_t push_entry;
    logic       pop_valid;
    logic       pop_ready;
    fhc_entry_t pop_entry;

    // Configuration writes are always taken; an index past the last register is dropped.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_MAX_FRAME_BYTES:  cfg_next.max_frame_bytes  = cfg_data;
                CFG_PROTOCOL_VERSION: cfg_next.protocol_version = cfg_data[15:0];
                CFG_UPDATE_TYPE_CODE: cfg_next.update_type_code = cfg_data[15:0];
                CFG_ACTION_TYPE_CODE: cfg_next.action_type_code = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_frame_bytes  <= 32'd1048576;
            cfg_reg.protocol_version <= 16'd1;
            cfg_reg.update_type_code <= 16'd1;
            cfg_reg.action_type_code <= 16'd2;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end counts bytes and tags each one as header or payload.
    fhc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // The queue lets the front keep taking bytes while a result waits on m_ready.
    fhc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // The back end does the header assembly, CRC and final checks.
    fhc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
